// File: src/lwfs_pkg.sv
// Package for the LCD window fill sequencer: shared constants, types and codes.
// Used by every module of the block and by the channel interfaces.
package lwfs_pkg;

  // Coordinate field width and the largest pixel size in bytes
  localparam int COORD_BITS      = 12;
  localparam int MAX_PIXEL_BYTES = 3;

  // Fixed field widths of the channels
  localparam int COORD_IN_W = 16;
  localparam int COLOR_W    = 24;
  localparam int SCREEN_W   = 13;
  localparam int PBITS_W    = 5;
  localparam int OPC_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int NB_W       = 2;
  localparam int ARITH_W    = 18;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_PIXEL_BITS    = 3'd2,
    REG_COLUMN_OPCODE = 3'd3,
    REG_ROW_OPCODE    = 3'd4,
    REG_MEMWRITE_OPC  = 3'd5
  } reg_idx_t;

  // Input word command codes
  localparam logic CMD_TICK    = 1'b0;
  localparam logic CMD_REQUEST = 1'b1;

  // Result kinds and status codes
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic DC_COMMAND  = 1'b0;
  localparam logic DC_DATA     = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_CLIPPED  = 2'd1,
    ST_BUSY     = 2'd2
  } status_t;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COLCMD,
    PH_COLDATA,
    PH_ROWCMD,
    PH_ROWDATA,
    PH_MEMCMD,
    PH_PIXEL
  } phase_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Configuration register file contents
  typedef struct packed {
    logic [SCREEN_W-1:0] screen_width;
    logic [SCREEN_W-1:0] screen_height;
    logic [PBITS_W-1:0]  pixel_bits;
    logic [OPC_W-1:0]    column_opcode;
    logic [OPC_W-1:0]    row_opcode;
    logic [OPC_W-1:0]    memwrite_opcode;
  } cfg_t;

  // Result of clipping one axis
  typedef struct packed {
    logic   ok;
    coord_t lo;
    coord_t hi;
  } clip_t;

  // Classified word held in the queue between front and back
  typedef struct packed {
    logic               is_req;
    logic               ok;
    coord_t             x0;
    coord_t             x1;
    coord_t             y0;
    coord_t             y1;
    logic [COLOR_W-1:0] color;
    logic [NB_W-1:0]    nbytes;
  } item_t;

endpackage

// File: src/lwfs_if.sv
// Handshake channel interfaces of the LCD window fill sequencer.
// Depends on lwfs_pkg for field widths.
interface lwfs_in_if
  import lwfs_pkg::*;
  ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic signed [COORD_IN_W-1:0] left_x;
  logic signed [COORD_IN_W-1:0] top_y;
  logic signed [COORD_IN_W-1:0] span_w;
  logic signed [COORD_IN_W-1:0] span_h;
  logic [COLOR_W-1:0]           fill_color;

  modport source (output valid, cmd, left_x, top_y, span_w, span_h, fill_color,
                  input ready);
  modport sink (input valid, cmd, left_x, top_y, span_w, span_h, fill_color,
                output ready);
endinterface

interface lwfs_out_if
  import lwfs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic             dc_flag;
  logic [OPC_W-1:0] bus_byte;
  logic             last_byte;
  logic [1:0]       status;

  modport source (output valid, kind, dc_flag, bus_byte, last_byte, status,
                  input ready);
  modport sink (input valid, kind, dc_flag, bus_byte, last_byte, status,
                output ready);
endinterface

interface lwfs_cfg_if
  import lwfs_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

// File: src/lwfs_front.sv
// Front end: classifies each input word and clips fill requests to the screen.
// Depends on lwfs_pkg and lwfs_in_if; feeds the queue with item_t words.
module lwfs_front
  import lwfs_pkg::*;
(
  lwfs_in_if.sink in_chan,
  input  cfg_t    cfg,
  input  logic    q_ready,
  output logic    q_push,
  output item_t   q_item
);

  localparam logic [ARITH_W-1:0] LIM = ARITH_W'(1) << COORD_BITS;

  logic [ARITH_W-1:0] lim_w;
  logic [ARITH_W-1:0] lim_h;
  clip_t              cx;
  clip_t              cy;
  logic [5:0]         pb_round;
  logic [2:0]         nb_raw;
  logic [NB_W-1:0]    nb;
  logic [COLOR_W-1:0] mask;

  // Clip one axis: start p, length len, limit lim
  function automatic clip_t clip_axis(input logic signed [COORD_IN_W-1:0] p,
                                      input logic signed [COORD_IN_W-1:0] len,
                                      input logic [ARITH_W-1:0] lim);
    logic signed [ARITH_W-1:0] p_x;
    logic signed [ARITH_W-1:0] l_x;
    logic signed [ARITH_W-1:0] e;
    logic signed [ARITH_W-1:0] a;
    logic signed [ARITH_W-1:0] lim_s;
    logic signed [ARITH_W-1:0] hi;
    clip_t r;
    p_x   = {{(ARITH_W-COORD_IN_W){p[COORD_IN_W-1]}}, p};
    l_x   = {{(ARITH_W-COORD_IN_W){len[COORD_IN_W-1]}}, len};
    lim_s = lim;
    e     = p_x + l_x;
    a     = p_x[ARITH_W-1] ? '0 : p_x;
    if (e > lim_s) begin
      e = lim_s;
    end
    hi    = e - ARITH_W'(1);
    r.ok  = !(len[COORD_IN_W-1] || len == '0) && (a < e);
    r.lo  = a[COORD_BITS-1:0];
    r.hi  = hi[COORD_BITS-1:0];
    return r;
  endfunction

  // Screen sizes saturate at the coordinate range
  always_comb begin
    lim_w = ARITH_W'(cfg.screen_width);
    lim_h = ARITH_W'(cfg.screen_height);
    if (lim_w > LIM) begin
      lim_w = LIM;
    end
    if (lim_h > LIM) begin
      lim_h = LIM;
    end
  end

  assign cx = clip_axis(in_chan.left_x, in_chan.span_w, lim_w);
  assign cy = clip_axis(in_chan.top_y, in_chan.span_h, lim_h);

  // Bytes per pixel, rounded up and held within one to the maximum
  assign pb_round = 6'(cfg.pixel_bits) + 6'd7;
  assign nb_raw   = pb_round[5:3];
  always_comb begin
    if (nb_raw == 3'd0) begin
      nb = NB_W'(1);
    end else if (nb_raw > 3'(MAX_PIXEL_BYTES)) begin
      nb = NB_W'(MAX_PIXEL_BYTES);
    end else begin
      nb = nb_raw[NB_W-1:0];
    end
  end

  // Colour mask keeps the low pixel_bits bits
  always_comb begin
    if (cfg.pixel_bits >= PBITS_W'(COLOR_W)) begin
      mask = '1;
    end else begin
      mask = COLOR_W'((25'd1 << cfg.pixel_bits) - 25'd1);
    end
  end

  // Classified word for the queue
  always_comb begin
    q_item.is_req = (in_chan.cmd == CMD_REQUEST);
    q_item.ok     = cx.ok && cy.ok;
    q_item.x0     = cx.lo;
    q_item.x1     = cx.hi;
    q_item.y0     = cy.lo;
    q_item.y1     = cy.hi;
    q_item.color  = in_chan.fill_color & mask;
    q_item.nbytes = nb;
  end

  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready;

endmodule

// File: src/lwfs_queue.sv
// Two-entry queue that decouples the front end from the byte sequencer.
// Depends on lwfs_pkg for the item_t word.
module lwfs_queue
  import lwfs_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  push_ready,
  input  logic  pop,
  output logic  pop_valid,
  output item_t pop_item
);

  item_t      mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: src/lwfs_back.sv
// Back end: runs the controller byte sequence and holds the output register.
// Depends on lwfs_pkg and lwfs_out_if; takes words from lwfs_queue.
module lwfs_back
  import lwfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  lwfs_out_if.source  out_chan
);

  phase_t             phase_r, phase_nxt;
  logic [1:0]         hdr_r, hdr_nxt;
  logic               row_pend_r, row_pend_nxt;
  coord_t             x0_r, x0_nxt, x1_r, x1_nxt;
  coord_t             y0_r, y0_nxt, y1_r, y1_nxt;
  coord_t             wspan_r, wspan_nxt;
  coord_t             col_left_r, col_left_nxt;
  coord_t             row_left_r, row_left_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic [NB_W-1:0]    nb_r, nb_nxt;
  logic [NB_W-1:0]    bidx_r, bidx_nxt;
  logic               cache_vld_r, cache_vld_nxt;
  coord_t             cx0_r, cx0_nxt, cx1_r, cx1_nxt;
  coord_t             cy0_r, cy0_nxt, cy1_r, cy1_nxt;

  logic               ovalid_r, ovalid_nxt;
  logic               okind_r, okind_nxt;
  logic               odc_r, odc_nxt;
  logic [OPC_W-1:0]   obyte_r, obyte_nxt;
  logic               olast_r, olast_nxt;
  logic [1:0]         ostat_r, ostat_nxt;

  logic               adv;
  logic               col_new;
  logic               row_new;
  logic [NB_W-1:0]    sel;
  logic               pix_done;
  logic               pix_last;

  // Pick one address byte, high byte first, low then high coordinate
  function automatic logic [OPC_W-1:0] addr_byte(input coord_t lo, input coord_t hi,
                                                 input logic [1:0] k);
    logic [15:0] v;
    v = k[1] ? 16'(hi) : 16'(lo);
    return k[0] ? v[7:0] : v[15:8];
  endfunction

  // A queue word moves on when the output register is free or being emptied
  assign adv   = q_valid && (!ovalid_r || out_chan.ready);
  assign q_pop = adv;

  assign col_new  = !cache_vld_r || (cx0_r != q_item.x0) || (cx1_r != q_item.x1);
  assign row_new  = !cache_vld_r || (cy0_r != q_item.y0) || (cy1_r != q_item.y1);
  assign sel      = nb_r - NB_W'(1) - bidx_r;
  assign pix_done = (bidx_r + NB_W'(1)) >= nb_r;
  assign pix_last = (col_left_r == '0) && (row_left_r == '0);

  // Sequencer next state and output word
  always_comb begin
    phase_nxt     = phase_r;
    hdr_nxt       = hdr_r;
    row_pend_nxt  = row_pend_r;
    x0_nxt        = x0_r;
    x1_nxt        = x1_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    wspan_nxt     = wspan_r;
    col_left_nxt  = col_left_r;
    row_left_nxt  = row_left_r;
    color_nxt     = color_r;
    nb_nxt        = nb_r;
    bidx_nxt      = bidx_r;
    cache_vld_nxt = cache_vld_r;
    cx0_nxt       = cx0_r;
    cx1_nxt       = cx1_r;
    cy0_nxt       = cy0_r;
    cy1_nxt       = cy1_r;

    ovalid_nxt = ovalid_r && !out_chan.ready;
    okind_nxt  = okind_r;
    odc_nxt    = odc_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    ostat_nxt  = ostat_r;

    if (adv) begin
      okind_nxt = KIND_BYTE;
      odc_nxt   = DC_COMMAND;
      obyte_nxt = '0;
      olast_nxt = 1'b0;
      ostat_nxt = ST_ACCEPTED;
      if (q_item.is_req) begin
        ovalid_nxt = 1'b1;
        okind_nxt  = KIND_STATUS;
        if (phase_r != PH_IDLE) begin
          ostat_nxt = ST_BUSY;
        end else if (!q_item.ok) begin
          ostat_nxt = ST_CLIPPED;
        end else begin
          x0_nxt        = q_item.x0;
          x1_nxt        = q_item.x1;
          y0_nxt        = q_item.y0;
          y1_nxt        = q_item.y1;
          wspan_nxt     = q_item.x1 - q_item.x0;
          col_left_nxt  = q_item.x1 - q_item.x0;
          row_left_nxt  = q_item.y1 - q_item.y0;
          color_nxt     = q_item.color;
          nb_nxt        = q_item.nbytes;
          bidx_nxt      = '0;
          hdr_nxt       = '0;
          row_pend_nxt  = row_new;
          cache_vld_nxt = 1'b1;
          cx0_nxt       = q_item.x0;
          cx1_nxt       = q_item.x1;
          cy0_nxt       = q_item.y0;
          cy1_nxt       = q_item.y1;
          if (col_new) begin
            phase_nxt = PH_COLCMD;
          end else if (row_new) begin
            phase_nxt = PH_ROWCMD;
          end else begin
            phase_nxt = PH_MEMCMD;
          end
        end
      end else begin
        ovalid_nxt = (phase_r != PH_IDLE);
        unique case (phase_r)
          PH_IDLE: begin
            phase_nxt = PH_IDLE;
          end
          PH_COLCMD: begin
            obyte_nxt = cfg.column_opcode;
            phase_nxt = PH_COLDATA;
            hdr_nxt   = '0;
          end
          PH_COLDATA: begin
            odc_nxt   = DC_DATA;
            obyte_nxt = addr_byte(x0_r, x1_r, hdr_r);
            hdr_nxt   = hdr_r + 2'd1;
            if (hdr_r == 2'd3) begin
              phase_nxt = row_pend_r ? PH_ROWCMD : PH_MEMCMD;
            end
          end
          PH_ROWCMD: begin
            obyte_nxt = cfg.row_opcode;
            phase_nxt = PH_ROWDATA;
            hdr_nxt   = '0;
          end
          PH_ROWDATA: begin
            odc_nxt   = DC_DATA;
            obyte_nxt = addr_byte(y0_r, y1_r, hdr_r);
            hdr_nxt   = hdr_r + 2'd1;
            if (hdr_r == 2'd3) begin
              phase_nxt = PH_MEMCMD;
            end
          end
          PH_MEMCMD: begin
            obyte_nxt = cfg.memwrite_opcode;
            phase_nxt = PH_PIXEL;
            bidx_nxt  = '0;
          end
          PH_PIXEL: begin
            odc_nxt = DC_DATA;
            case (sel)
              2'd0:    obyte_nxt = color_r[7:0];
              2'd1:    obyte_nxt = color_r[15:8];
              default: obyte_nxt = color_r[23:16];
            endcase
            olast_nxt = pix_last && pix_done;
            bidx_nxt  = bidx_r + NB_W'(1);
            if (pix_done) begin
              bidx_nxt = '0;
              if (pix_last) begin
                phase_nxt = PH_IDLE;
              end else if (col_left_r == '0) begin
                col_left_nxt = wspan_r;
                row_left_nxt = row_left_r - COORD_BITS'(1);
              end else begin
                col_left_nxt = col_left_r - COORD_BITS'(1);
              end
            end
          end
          default: begin
            phase_nxt = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      cache_vld_r <= 1'b0;
      ovalid_r    <= 1'b0;
      hdr_r       <= '0;
      bidx_r      <= '0;
      row_pend_r  <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cache_vld_r <= cache_vld_nxt;
      ovalid_r    <= ovalid_nxt;
      hdr_r       <= hdr_nxt;
      bidx_r      <= bidx_nxt;
      row_pend_r  <= row_pend_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    x0_r       <= x0_nxt;
    x1_r       <= x1_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    wspan_r    <= wspan_nxt;
    col_left_r <= col_left_nxt;
    row_left_r <= row_left_nxt;
    color_r    <= color_nxt;
    nb_r       <= nb_nxt;
    cx0_r      <= cx0_nxt;
    cx1_r      <= cx1_nxt;
    cy0_r      <= cy0_nxt;
    cy1_r      <= cy1_nxt;
    okind_r    <= okind_nxt;
    odc_r      <= odc_nxt;
    obyte_r    <= obyte_nxt;
    olast_r    <= olast_nxt;
    ostat_r    <= ostat_nxt;
  end

  assign out_chan.valid     = ovalid_r;
  assign out_chan.kind      = okind_r;
  assign out_chan.dc_flag   = odc_r;
  assign out_chan.bus_byte  = obyte_r;
  assign out_chan.last_byte = olast_r;
  assign out_chan.status    = ostat_r;

endmodule

// File: src/lcd_window_fill_sequencer.sv
// Top level of the LCD window fill sequencer: configuration registers, front
// end, queue and byte sequencer. Depends on lwfs_pkg, lwfs_if and the lwfs_ modules.
//
// Usage: in_chan carries one word per handshake. A word with cmd set is a fill
// request (rectangle and colour); it is answered with one status word. A word
// with cmd clear is a bus tick; while a fill is in progress it yields the next
// controller byte (column and row window commands only when the window changed,
// then memory write, then the pixel bytes, most significant first), and while
// idle it yields nothing. A request arriving mid-fill gets the busy status.
// cfg_chan writes the six registers by index and is always ready; write it only
// while the block is idle.
// A word's result is registered in lwfs_back's output register after the word has passed through the queue.
// Throughput: one word per cycle while out_chan does not stall; the
// two-entry queue and the output register let the sides stall independently.
// When out_chan stalls, words collect in the queue and in_chan.ready drops once
// the queue holds two of them.
// Reset (rst_n low at a clock edge) restores the register defaults, empties the
// queue, returns the sequencer to idle and forgets the cached window.
module lcd_window_fill_sequencer
  import lwfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  lwfs_in_if.sink    in_chan,
  lwfs_out_if.source out_chan,
  lwfs_cfg_if.sink   cfg_chan
);

  cfg_t  cfg_r;
  cfg_t  cfg_nxt;
  logic  q_push;
  logic  q_ready;
  item_t q_in;
  logic  q_pop;
  logic  q_valid;
  item_t q_out;

  // Configuration register file
  assign cfg_chan.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_chan.valid) begin
      unique case (cfg_chan.reg_index)
        REG_SCREEN_WIDTH:  cfg_nxt.screen_width    = cfg_chan.wdata[SCREEN_W-1:0];
        REG_SCREEN_HEIGHT: cfg_nxt.screen_height   = cfg_chan.wdata[SCREEN_W-1:0];
        REG_PIXEL_BITS:    cfg_nxt.pixel_bits      = cfg_chan.wdata[PBITS_W-1:0];
        REG_COLUMN_OPCODE: cfg_nxt.column_opcode   = cfg_chan.wdata[OPC_W-1:0];
        REG_ROW_OPCODE:    cfg_nxt.row_opcode      = cfg_chan.wdata[OPC_W-1:0];
        REG_MEMWRITE_OPC:  cfg_nxt.memwrite_opcode = cfg_chan.wdata[OPC_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width    <= SCREEN_W'(240);
      cfg_r.screen_height   <= SCREEN_W'(320);
      cfg_r.pixel_bits      <= PBITS_W'(16);
      cfg_r.column_opcode   <= OPC_W'(42);
      cfg_r.row_opcode      <= OPC_W'(43);
      cfg_r.memwrite_opcode <= OPC_W'(44);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Classify and clip
  lwfs_front u_front (
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_item  (q_in)
  );

  // Decoupling queue
  lwfs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_out)
  );

  // Byte sequencer and output register
  lwfs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_valid  (q_valid),
    .q_item   (q_out),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// File: tb/sv/tb_lcd_window_fill_sequencer.sv
`timescale 1ns / 100ps
// Self-checking testbench for lcd_window_fill_sequencer: drives fill requests and bus ticks,
// writes the registers between phases and checks result words against a predictor or a given word.
// Depends on lwfs_pkg, the lwfs_ channel interfaces and the block's RTL.
module tb_lcd_window_fill_sequencer;
  import lwfs_pkg::*;

  // One input word as the testbench sees it
  typedef struct {
    logic                         cmd;
    logic signed [COORD_IN_W-1:0] left_x;
    logic signed [COORD_IN_W-1:0] top_y;
    logic signed [COORD_IN_W-1:0] span_w;
    logic signed [COORD_IN_W-1:0] span_h;
    logic [COLOR_W-1:0]           fill_color;
  } fill_word_t;

  // One result word
  typedef struct packed {
    logic             kind;
    logic             dc_flag;
    logic [OPC_W-1:0] bus_byte;
    logic             last_byte;
    status_t          status;
  } lcd_result_t;

  // How the result of a driven word is judged
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NOTHING,
    CHK_GIVEN
  } check_mode_t;

  typedef struct {
    fill_word_t  w;
    check_mode_t chk;
    lcd_result_t want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  lwfs_in_if  in_chan ();
  lwfs_out_if out_chan ();
  lwfs_cfg_if cfg_chan ();

  lcd_window_fill_sequencer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Register copies held by the predictor
  logic [SCREEN_W-1:0] scr_w_q, scr_h_q;
  logic [PBITS_W-1:0]  pix_bits_q;
  logic [OPC_W-1:0]    col_opc_q, row_opc_q, mem_opc_q;

  // Predicted sequencer state
  logic [15:0]        cache_x0, cache_x1, cache_y0, cache_y1;
  coord_t             win_x0, win_x1, win_y0, win_y1;
  logic [COLOR_W-1:0] fill_rgb;
  phase_t             fill_phase;
  int unsigned        addr_idx, px_remaining, px_byte, px_nbytes;
  bit                 rows_dirty;

  // Result words still owed by the block, oldest first
  lcd_result_t awaited[$];
  int          mismatch_count;
  int          words_sent;

  // Driver side controls
  check_mode_t in_check;
  lcd_result_t in_given;
  bit          steady_flow;
  int          hold_reqs, hold_done;
  int          last_x, last_y, last_w, last_h;
  bit          have_last;
  stim_row_t   directed_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("lcd_window_fill_sequencer: mismatch");
    $finish;
  end

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("error at %0t: %s", $realtime, msg);
  endtask

  // Screen size as used for clipping: saturated to the coordinate range.
  function automatic int visible(input logic [SCREEN_W-1:0] s);
    return (s > (1 << COORD_BITS)) ? (1 << COORD_BITS) : int'(s);
  endfunction

  function automatic lcd_result_t status_res(input status_t s);
    lcd_result_t r;
    r = '0;
    r.kind = KIND_STATUS;
    r.status = s;
    return r;
  endfunction

  function automatic lcd_result_t bus_res(input logic dc, input logic [7:0] b,
                                          input logic last);
    lcd_result_t r;
    r = '0;
    r.kind = KIND_BYTE;
    r.dc_flag = dc;
    r.bus_byte = b;
    r.last_byte = last;
    return r;
  endfunction

  // Clips one axis; false when nothing of it is left on screen.
  function automatic bit clip_axis(input int p, input int len, input int lim,
                                   output int lo, output int hi);
    int e, a;
    lo = 0;
    hi = 0;
    if (len <= 0) return 0;
    e = p + len;
    a = (p < 0) ? 0 : p;
    if (e > lim) e = lim;
    if (a >= e) return 0;
    lo = a;
    hi = e - 1;
    return 1;
  endfunction

  // Address bytes go out as start high, start low, end high, end low.
  function automatic logic [7:0] window_byte(input coord_t lo, input coord_t hi,
                                             input int unsigned k);
    coord_t v;
    v = k[1] ? hi : lo;
    return k[0] ? v[7:0] : 8'(v >> 8);
  endfunction

  function automatic void clear_fill_state();
    scr_w_q = 13'd240;
    scr_h_q = 13'd320;
    pix_bits_q = 5'd16;
    col_opc_q = 8'd42;
    row_opc_q = 8'd43;
    mem_opc_q = 8'd44;
    cache_x0 = 16'hFFFF;
    cache_x1 = 16'hFFFF;
    cache_y0 = 16'hFFFF;
    cache_y1 = 16'hFFFF;
    win_x0 = '0;
    win_x1 = '0;
    win_y0 = '0;
    win_y1 = '0;
    fill_rgb = '0;
    fill_phase = PH_IDLE;
    addr_idx = 0;
    px_remaining = 0;
    px_byte = 0;
    px_nbytes = 1;
    rows_dirty = 1'b0;
  endfunction

  // Advances the predicted sequencer by one accepted word; returns 1 when the
  // word yields a result, which is then placed in r.
  function automatic bit advance_fill(input fill_word_t w, output lcd_result_t r);
    int          x0, x1, y0, y1;
    int unsigned shift;
    bit          col_dirty;
    logic [23:0] mask;
    r = '0;
    if (w.cmd == CMD_REQUEST) begin
      if (fill_phase != PH_IDLE) begin
        r = status_res(ST_BUSY);
        return 1;
      end
      if (!clip_axis(w.left_x, w.span_w, visible(scr_w_q), x0, x1) ||
          !clip_axis(w.top_y, w.span_h, visible(scr_h_q), y0, y1)) begin
        r = status_res(ST_CLIPPED);
        return 1;
      end
      win_x0 = coord_t'(x0);
      win_x1 = coord_t'(x1);
      win_y0 = coord_t'(y0);
      win_y1 = coord_t'(y1);
      // Pixel size and colour are latched with the request.
      px_nbytes = (pix_bits_q + 7) / 8;
      if (px_nbytes < 1) px_nbytes = 1;
      if (px_nbytes > MAX_PIXEL_BYTES) px_nbytes = MAX_PIXEL_BYTES;
      mask = (pix_bits_q >= 5'd24) ? 24'hFFFFFF : 24'((32'd1 << pix_bits_q) - 32'd1);
      fill_rgb = w.fill_color & mask;
      px_remaining = (x1 - x0 + 1) * (y1 - y0 + 1);
      px_byte = 0;
      addr_idx = 0;
      col_dirty = (cache_x0 != x0[15:0]) || (cache_x1 != x1[15:0]);
      rows_dirty = (cache_y0 != y0[15:0]) || (cache_y1 != y1[15:0]);
      cache_x0 = x0[15:0];
      cache_x1 = x1[15:0];
      cache_y0 = y0[15:0];
      cache_y1 = y1[15:0];
      fill_phase = col_dirty ? PH_COLCMD : (rows_dirty ? PH_ROWCMD : PH_MEMCMD);
      r = status_res(ST_ACCEPTED);
      return 1;
    end
    case (fill_phase)
      PH_COLCMD: begin
        r = bus_res(DC_COMMAND, col_opc_q, 1'b0);
        fill_phase = PH_COLDATA;
        addr_idx = 0;
      end
      PH_COLDATA: begin
        r = bus_res(DC_DATA, window_byte(win_x0, win_x1, addr_idx), 1'b0);
        addr_idx++;
        if (addr_idx >= 4) begin
          addr_idx = 0;
          fill_phase = rows_dirty ? PH_ROWCMD : PH_MEMCMD;
        end
      end
      PH_ROWCMD: begin
        r = bus_res(DC_COMMAND, row_opc_q, 1'b0);
        fill_phase = PH_ROWDATA;
        addr_idx = 0;
      end
      PH_ROWDATA: begin
        r = bus_res(DC_DATA, window_byte(win_y0, win_y1, addr_idx), 1'b0);
        addr_idx++;
        if (addr_idx >= 4) begin
          addr_idx = 0;
          fill_phase = PH_MEMCMD;
        end
      end
      PH_MEMCMD: begin
        r = bus_res(DC_COMMAND, mem_opc_q, 1'b0);
        fill_phase = PH_PIXEL;
        px_byte = 0;
      end
      PH_PIXEL: begin
        // Most significant byte of the pixel first.
        shift = 8 * ((px_nbytes - 1 - px_byte) & 3);
        r = bus_res(DC_DATA, 8'(fill_rgb >> shift),
                    (px_remaining <= 1) && (px_byte + 1 >= px_nbytes));
        px_byte++;
        if (px_byte >= px_nbytes) begin
          px_byte = 0;
          if (px_remaining > 0) px_remaining--;
          if (px_remaining == 0) fill_phase = PH_IDLE;
        end
      end
      default: begin
        // A tick while idle yields nothing.
        fill_phase = PH_IDLE;
        return 0;
      end
    endcase
    return 1;
  endfunction

  // Checks result words, tracks register writes and predicts each accepted word.
  always @(posedge clk) begin : check_and_predict
    lcd_result_t got, want, predicted;
    fill_word_t  w;
    bit          has;
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready) begin
        got.kind = out_chan.kind;
        got.dc_flag = out_chan.dc_flag;
        got.bus_byte = out_chan.bus_byte;
        got.last_byte = out_chan.last_byte;
        got.status = status_t'(out_chan.status);
        if (awaited.size() == 0) begin
          flag_mismatch($sformatf("unexpected word kind %0d dc %0d byte %02h last %0d status %0d",
                                  got.kind, got.dc_flag, got.bus_byte, got.last_byte,
                                  got.status));
        end else begin
          want = awaited.pop_front();
          if (got.kind !== want.kind || got.dc_flag !== want.dc_flag ||
              got.bus_byte !== want.bus_byte || got.last_byte !== want.last_byte ||
              got.status !== want.status)
            flag_mismatch($sformatf({"got kind %0d dc %0d byte %02h last %0d status %0d, ",
                                     "want kind %0d dc %0d byte %02h last %0d status %0d"},
                                    got.kind, got.dc_flag, got.bus_byte, got.last_byte,
                                    got.status, want.kind, want.dc_flag, want.bus_byte,
                                    want.last_byte, want.status));
        end
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.reg_index)
          REG_SCREEN_WIDTH:  scr_w_q = cfg_chan.wdata[SCREEN_W-1:0];
          REG_SCREEN_HEIGHT: scr_h_q = cfg_chan.wdata[SCREEN_W-1:0];
          REG_PIXEL_BITS:    pix_bits_q = cfg_chan.wdata[PBITS_W-1:0];
          REG_COLUMN_OPCODE: col_opc_q = cfg_chan.wdata[OPC_W-1:0];
          REG_ROW_OPCODE:    row_opc_q = cfg_chan.wdata[OPC_W-1:0];
          REG_MEMWRITE_OPC:  mem_opc_q = cfg_chan.wdata[OPC_W-1:0];
          default: ;
        endcase
      end
      if (in_chan.valid && in_chan.ready) begin
        w.cmd = in_chan.cmd;
        w.left_x = in_chan.left_x;
        w.top_y = in_chan.top_y;
        w.span_w = in_chan.span_w;
        w.span_h = in_chan.span_h;
        w.fill_color = in_chan.fill_color;
        has = advance_fill(w, predicted);
        case (in_check)
          CHK_GIVEN: awaited.push_back(in_given);
          CHK_MODEL: if (has) awaited.push_back(predicted);
          default: ;
        endcase
      end
    end
  end

  // Result side: random stalls, plus a long hold-off when one is requested.
  initial begin
    out_chan.ready = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_reqs != hold_done) begin
        hold_done = hold_reqs;
        out_chan.ready = 1'b0;
        repeat (64) @(negedge clk);
      end
      out_chan.ready = steady_flow || ($urandom_range(99) >= 16);
    end
  end

  function automatic fill_word_t req(input int x, input int y, input int w, input int h,
                                     input logic [23:0] c);
    fill_word_t r;
    r.cmd = CMD_REQUEST;
    r.left_x = 16'(x);
    r.top_y = 16'(y);
    r.span_w = 16'(w);
    r.span_h = 16'(h);
    r.fill_color = c;
    return r;
  endfunction

  function automatic fill_word_t random_word();
    fill_word_t r;
    r.cmd = 1'($urandom_range(1));
    r.left_x = 16'($urandom);
    r.top_y = 16'($urandom);
    r.span_w = 16'($urandom);
    r.span_h = 16'($urandom);
    r.fill_color = 24'($urandom);
    return r;
  endfunction

  // A bus tick; the payload carries random bits that the block ignores.
  function automatic fill_word_t tick_word();
    fill_word_t r;
    r = random_word();
    r.cmd = CMD_TICK;
    return r;
  endfunction

  // Offers one word, after an occasional idle gap, and waits for its acceptance.
  task automatic send_word(input fill_word_t w, input check_mode_t chk = CHK_MODEL,
                           input lcd_result_t want = '0);
    int gap;
    gap = 0;
    if (!steady_flow && $urandom_range(99) < 16) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid = 1'b1;
    in_chan.cmd = w.cmd;
    in_chan.left_x = w.left_x;
    in_chan.top_y = w.top_y;
    in_chan.span_w = w.span_w;
    in_chan.span_h = w.span_h;
    in_chan.fill_color = w.fill_color;
    in_check = chk;
    in_given = want;
    do @(posedge clk); while (!in_chan.ready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input int value);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.reg_index = idx;
    cfg_chan.wdata = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk);
    cfg_chan.valid = 1'b0;
  endtask

  // Finishes any fill in progress and waits until the block has gone quiet.
  task automatic settle();
    while (fill_phase != PH_IDLE) send_word(tick_word());
    in_chan.valid = 1'b0;
    in_check = CHK_MODEL;
    while (awaited.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Picks a start and a length for one axis: lengths mostly small, starts often near the edges.
  task automatic pick_axis(input int lim, output int p, output int len);
    case ($urandom_range(3))
      0: p = int'($urandom_range(6)) - 3;
      1: p = lim - int'($urandom_range(5));
      default: p = $urandom_range(lim);
    endcase
    if ($urandom_range(49) == 0) len = $urandom_range(1, 16);
    else len = int'($urandom_range(6)) - 1;
  endtask

  // One fill: a request and the ticks that drain it, with the odd request
  // while busy and the odd early break that leaves the fill running.
  task automatic fill_sequence();
    int         x, y, w, h, mode, roll;
    fill_word_t busy_req;
    mode = $urandom_range(99);
    pick_axis(visible(scr_w_q), x, w);
    pick_axis(visible(scr_h_q), y, h);
    // Reuse of the last window exercises the cached column and row windows.
    if (have_last && mode < 30) begin
      x = last_x;
      w = last_w;
    end
    if (have_last && (mode < 20 || (mode >= 30 && mode < 40))) begin
      y = last_y;
      h = last_h;
    end
    last_x = x;
    last_y = y;
    last_w = w;
    last_h = h;
    have_last = 1'b1;
    send_word(req(x, y, w, h, 24'($urandom)));
    while (fill_phase != PH_IDLE) begin
      roll = $urandom_range(99);
      if (roll < 4) begin
        busy_req = random_word();
        busy_req.cmd = CMD_REQUEST;
        send_word(busy_req);
      end else if (roll < 7) begin
        break;
      end else begin
        send_word(tick_word());
      end
    end
    if ($urandom_range(99) < 20) repeat ($urandom_range(1, 2)) send_word(tick_word());
  endtask

  task automatic run_phase(input int sw, input int sh, input int pb, input int copc,
                           input int ropc, input int mopc, input int budget,
                           input bit steady, input bit pressure);
    int         start;
    fill_word_t noise;
    write_reg(REG_SCREEN_WIDTH, sw);
    write_reg(REG_SCREEN_HEIGHT, sh);
    write_reg(REG_PIXEL_BITS, pb);
    write_reg(REG_COLUMN_OPCODE, copc);
    write_reg(REG_ROW_OPCODE, ropc);
    write_reg(REG_MEMWRITE_OPC, mopc);
    steady_flow = steady;
    if (pressure) hold_reqs++;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(99) < 12) begin
        // Random word; a request that could open a huge fill becomes a tick.
        noise = random_word();
        if (noise.cmd == CMD_REQUEST && fill_phase == PH_IDLE &&
            visible(scr_w_q) * visible(scr_h_q) > 800)
          noise.cmd = CMD_TICK;
        send_word(noise);
      end else begin
        fill_sequence();
      end
    end
    settle();
    steady_flow = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.cmd = CMD_TICK;
    in_chan.left_x = '0;
    in_chan.top_y = '0;
    in_chan.span_w = '0;
    in_chan.span_h = '0;
    in_chan.fill_color = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.reg_index = REG_SCREEN_WIDTH;
    cfg_chan.wdata = '0;
    in_check = CHK_MODEL;
    in_given = '0;
    steady_flow = 1'b0;
    hold_reqs = 0;
    have_last = 1'b0;
    mismatch_count = 0;
    words_sent = 0;
    clear_fill_state();

    // Directed words on the reset settings: 240 x 320, 16 bits, opcodes 42/43/44.
    directed_rows.push_back('{tick_word(), CHK_NOTHING, '0});
    directed_rows.push_back('{req(0, 0, 1, 1, 24'hABCDEF), CHK_GIVEN, status_res(ST_ACCEPTED)});
    directed_rows.push_back('{req(32767, 32767, 32767, 32767, 24'hFFFFFF), CHK_GIVEN,
                              status_res(ST_BUSY)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_COMMAND, 8'd42, 1'b0)});
    repeat (4) directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'h00, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_COMMAND, 8'd43, 1'b0)});
    repeat (4) directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'h00, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_COMMAND, 8'd44, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'hCD, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'hEF, 1'b1)});
    // Same window again: the cached window lets the fill start at memory write.
    directed_rows.push_back('{req(0, 0, 1, 1, 24'h001234), CHK_GIVEN, status_res(ST_ACCEPTED)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_COMMAND, 8'd44, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'h12, 1'b0)});
    directed_rows.push_back('{tick_word(), CHK_GIVEN, bus_res(DC_DATA, 8'h34, 1'b1)});
    // Rectangles that clip away entirely.
    directed_rows.push_back('{req(10, 10, 0, 5, 24'hFFFFFF), CHK_GIVEN, status_res(ST_CLIPPED)});
    directed_rows.push_back('{req(0, 0, 5, -32768, 24'h000000), CHK_GIVEN,
                              status_res(ST_CLIPPED)});
    directed_rows.push_back('{req(32767, 0, 32767, 1, 24'h555555), CHK_GIVEN,
                              status_res(ST_CLIPPED)});
    directed_rows.push_back('{req(-32768, -32768, 32767, 32767, 24'hAAAAAA), CHK_GIVEN,
                              status_res(ST_CLIPPED)});
    // Partly off screen on the left and at the bottom edge.
    directed_rows.push_back('{req(-2, 319, 4, 9, 24'hFFFFFF), CHK_GIVEN,
                              status_res(ST_ACCEPTED)});
    repeat (2) directed_rows.push_back('{tick_word(), CHK_MODEL, '0});

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) send_word(directed_rows[i].w, directed_rows[i].chk,
                                         directed_rows[i].want);
    settle();

    // Random phases, each on its own register settings.
    run_phase(240, 320, 16, 42, 43, 44, 220, 1'b0, 1'b1);
    run_phase(1, 1, 8, 0, 255, 8'h5A, 150, 1'b0, 1'b0);
    run_phase(8191, 4096, 24, 255, 0, 8'hA5, 200, 1'b1, 1'b0);
    run_phase(0, 100, 31, 8'h0F, 8'hF0, 8'h81, 100, 1'b0, 1'b0);
    run_phase(37, 19, 0, 8'h2A, 8'h2B, 8'h2C, 150, 1'b0, 1'b0);
    run_phase(4097, 8191, 9, 8'h7E, 8'h81, 8'hFF, 200, 1'b0, 1'b0);
    repeat (2) run_phase($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(31),
                         $urandom_range(255), $urandom_range(255), $urandom_range(255),
                         200, 1'b0, 1'b0);

    repeat (10) @(posedge clk);
    if (awaited.size() != 0) flag_mismatch("result words still outstanding at the end");
    if (mismatch_count == 0) $display("lcd_window_fill_sequencer: match");
    else $display("lcd_window_fill_sequencer: mismatch");
    $finish;
  end

endmodule
